>>> rtl/sib_pkg.sv
`default_nettype none
package sib_pkg;

	localparam int DEPTH_DEF      = 32;
	localparam int VALUE_BITS_DEF = 16;

	// Fixed widths of the stream fields.
	localparam int VALUE_W = 16;
	localparam int CMD_W   = 2;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 24;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT    = 2'd0,
		CMD_READ_ASC  = 2'd1,
		CMD_READ_DESC = 2'd2
	} cmd_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage
`default_nettype wire

>>> rtl/sorted_insert_buffer_top.sv
`default_nettype none
// Sorted insert buffer: keeps up to DEPTH unsigned values in ascending order in a
// memory with one write port and a registered read port. An insert (tuser 0)
// places the value ahead of any equal entries and gives one transfer with status
// set when the store was full; a read (tuser 1 ascending, 2 descending) gives one
// transfer per stored entry with tlast on the final one, or a single empty
// transfer. One shared compare unit walks the memory from the top, one read and
// one write per entry moved. s_axis_tready stays low while a command is handled:
// through the walk and the response of an insert, through every stored entry of
// a readout, and through the response of a dropped insert, an empty read or an
// unused command. The walk and the readout are paced by the one memory read
// port, and a result that waits on m_axis_tready holds it low for longer. No
// clearing pass is needed after reset.
module sorted_insert_buffer_top #(
	parameter int DEPTH      = sib_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = sib_pkg::VALUE_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire  [sib_pkg::S_DATA_W-1:0]   s_axis_tdata,  // new_value
	input  wire  [sib_pkg::CMD_W-1:0]      s_axis_tuser,  // command
	output logic                           m_axis_tvalid,
	input  wire                            m_axis_tready,
	output logic [sib_pkg::M_DATA_W-1:0]   m_axis_tdata,  // value, list_empty, status
	output logic                           m_axis_tuser,  // value_valid
	output logic                           m_axis_tlast
);
	import sib_pkg::*;

	localparam int AW = $clog2(DEPTH);

	mem_ctl_t              mem_ctl;
	logic [AW-1:0]         mem_wr_addr;
	logic [AW-1:0]         mem_rd_addr;
	logic [VALUE_BITS-1:0] mem_wr_data;
	logic [VALUE_BITS-1:0] mem_rd_data;
	logic [VALUE_W-1:0]    out_value;
	logic                  out_list_empty;
	logic                  out_status;

	sib_store #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_store (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	sib_seq #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.in_cmd          (cmd_t'(s_axis_tuser)),
		.in_value        (s_axis_tdata[VALUE_W-1:0]),
		.mem_ctl         (mem_ctl),
		.mem_wr_addr     (mem_wr_addr),
		.mem_wr_data     (mem_wr_data),
		.mem_rd_addr     (mem_rd_addr),
		.mem_rd_data     (mem_rd_data),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_value       (out_value),
		.out_value_valid (m_axis_tuser),
		.out_last        (m_axis_tlast),
		.out_list_empty  (out_list_empty),
		.out_status      (out_status)
	);

	assign m_axis_tdata = {{(M_DATA_W - VALUE_W - 2){1'b0}}, out_status, out_list_empty,
		out_value};

endmodule
`default_nettype wire

>>> rtl/sib_store.sv
`default_nettype none
module sib_store #(
	parameter int DEPTH      = 32,
	parameter int VALUE_BITS = 16
) (
	input  wire                          clk,
	input  sib_pkg::mem_ctl_t            ctl,
	input  wire  [$clog2(DEPTH)-1:0]     wr_addr,
	input  wire  [VALUE_BITS-1:0]        wr_data,
	input  wire  [$clog2(DEPTH)-1:0]     rd_addr,
	output logic [VALUE_BITS-1:0]        rd_data
);
	import sib_pkg::*;

	logic [VALUE_BITS-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/sib_seq.sv
`default_nettype none
module sib_seq #(
	parameter int DEPTH      = 32,
	parameter int VALUE_BITS = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  sib_pkg::cmd_t                    in_cmd,
	input  wire  [sib_pkg::VALUE_W-1:0]      in_value,
	output sib_pkg::mem_ctl_t                mem_ctl,
	output logic [$clog2(DEPTH)-1:0]         mem_wr_addr,
	output logic [VALUE_BITS-1:0]            mem_wr_data,
	output logic [$clog2(DEPTH)-1:0]         mem_rd_addr,
	input  wire  [VALUE_BITS-1:0]            mem_rd_data,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [sib_pkg::VALUE_W-1:0]      out_value,
	output logic                             out_value_valid,
	output logic                             out_last,
	output logic                             out_list_empty,
	output logic                             out_status
);
	import sib_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_INS_RD  = 6'b000010,
		ST_INS_CMP = 6'b000100,
		ST_RD_RD   = 6'b001000,
		ST_RD_OUT  = 6'b010000,
		ST_RESP    = 6'b100000
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         ptr_q;
	logic [VALUE_BITS-1:0] nv_q;
	logic                  desc_q;
	logic                  status_q;
	logic                  out_valid_q;
	logic [VALUE_W-1:0]    out_value_q;
	logic                  out_value_valid_q;
	logic                  out_last_q;
	logic                  out_empty_q;
	logic                  out_status_q;

	logic                  out_free;
	logic                  shift_up;
	logic [CW-1:0]         ptr_m1;
	logic [CW-1:0]         rev_idx;
	logic                  read_last;
	logic                  load_entry;
	logic                  load_resp;

	assign out_free   = !out_valid_q || out_ready;
	// The shared comparator: entries not smaller than the new value move up one place.
	assign shift_up   = (mem_rd_data >= nv_q);
	assign ptr_m1     = ptr_q - CW'(1);
	assign rev_idx    = count_q - CW'(1) - ptr_q;
	assign read_last  = (ptr_q == count_q - CW'(1));
	assign load_entry = (state_q == ST_RD_OUT) && out_free;
	assign load_resp  = (state_q == ST_RESP) && out_free;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		mem_ctl     = '0;
		mem_wr_addr = ptr_q[AW-1:0];
		mem_wr_data = nv_q;
		mem_rd_addr = ptr_m1[AW-1:0];
		unique case (state_q)
			ST_INS_RD: begin
				if (ptr_q == '0) begin
					mem_ctl.wr_en = 1'b1;
				end else begin
					mem_ctl.rd_en = 1'b1;
				end
			end
			ST_INS_CMP: begin
				mem_ctl.wr_en = 1'b1;
				if (shift_up) begin
					mem_wr_data = mem_rd_data;
				end
			end
			ST_RD_RD: begin
				mem_ctl.rd_en = 1'b1;
				mem_rd_addr   = desc_q ? rev_idx[AW-1:0] : ptr_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			desc_q      <= 1'b0;
			status_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_entry || load_resp) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (in_cmd) inside
							CMD_INSERT: begin
								if (count_q == CW'(DEPTH)) begin
									status_q <= 1'b1;
									state_q  <= ST_RESP;
								end else begin
									status_q <= 1'b0;
									ptr_q    <= count_q;
									state_q  <= ST_INS_RD;
								end
							end
							CMD_READ_ASC, CMD_READ_DESC: begin
								status_q <= 1'b0;
								ptr_q    <= '0;
								desc_q   <= (in_cmd == CMD_READ_DESC);
								state_q  <= (count_q == '0) ? ST_RESP : ST_RD_RD;
							end
							default: begin
								status_q <= 1'b0;
								state_q  <= ST_RESP;
							end
						endcase
					end
				end
				ST_INS_RD: begin
					if (ptr_q == '0) begin
						count_q <= count_q + CW'(1);
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					if (shift_up) begin
						ptr_q   <= ptr_m1;
						state_q <= ST_INS_RD;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= ST_RESP;
					end
				end
				ST_RD_RD: begin
					state_q <= ST_RD_OUT;
				end
				ST_RD_OUT: begin
					if (out_free) begin
						if (read_last) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q   <= ptr_q + CW'(1);
							state_q <= ST_RD_RD;
						end
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			nv_q <= VALUE_BITS'(in_value);
		end
		if (load_entry) begin
			out_value_q       <= VALUE_W'(mem_rd_data);
			out_value_valid_q <= 1'b1;
			out_last_q        <= read_last;
			out_empty_q       <= 1'b0;
			out_status_q      <= 1'b0;
		end else if (load_resp) begin
			out_value_q       <= '0;
			out_value_valid_q <= 1'b0;
			out_last_q        <= 1'b1;
			out_empty_q       <= (count_q == '0);
			out_status_q      <= status_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_value       = out_value_q;
	assign out_value_valid = out_value_valid_q;
	assign out_last        = out_last_q;
	assign out_list_empty  = out_empty_q;
	assign out_status      = out_status_q;

endmodule
`default_nettype wire

>>> dv/sorted_insert_buffer_top_test.sv
module sorted_insert_buffer_top_test;
	import sib_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int VALUE_BITS = VALUE_BITS_DEF;
	localparam logic [VALUE_W-1:0] VALUE_MASK = (VALUE_BITS >= VALUE_W) ? {VALUE_W{1'b1}} :
		VALUE_W'((64'd1 << VALUE_BITS) - 64'd1);
	// Command code outside the enum; the block must ignore it.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS     = 300;
	localparam int LONG_HOLD_CYCLES = 400;
	// Settle margin: long enough for the longest insert, which walks every entry.
	localparam int SETTLE_CYCLES    = 2 * DEPTH + 40;

	typedef struct {
		logic [CMD_W-1:0]   cmd;
		logic [VALUE_W-1:0] value;
	} command_item_t;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               value_valid;
		logic               last;
		logic               list_empty;
		logic               status;
	} readout_t;

	class sorted_list_tracker;
		logic [VALUE_W-1:0] shadow_values[DEPTH];
		int                 shadow_count;
		readout_t           pending_results[$];
		int                 mismatches;
		int                 checked;
		int                 inserts;
		int                 drops;
		int                 readouts;
		int                 ignored;

		function new();
			shadow_count = 0;
			mismatches   = 0;
			checked      = 0;
			inserts      = 0;
			drops        = 0;
			readouts     = 0;
			ignored      = 0;
		endfunction

		function void push_result(logic [VALUE_W-1:0] value, logic valid, logic last,
				logic status);
			readout_t r;
			r.value       = value;
			r.value_valid = valid;
			r.last        = last;
			r.list_empty  = (shadow_count == 0);
			r.status      = status;
			pending_results.push_back(r);
		endfunction

		// Works out the transfers that one accepted command causes.
		function void note_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] new_value);
			logic [VALUE_W-1:0] kept;
			int                 pos;
			kept = new_value & VALUE_MASK;
			if (cmd == CMD_INSERT) begin
				inserts++;
				if (shadow_count >= DEPTH) begin
					drops++;
					push_result('0, 1'b0, 1'b1, 1'b1);
				end else begin
					pos = 0;
					while (pos < shadow_count && shadow_values[pos] < kept)
						pos++;
					for (int i = shadow_count; i > pos; i--)
						shadow_values[i] = shadow_values[i-1];
					shadow_values[pos] = kept;
					shadow_count++;
					push_result('0, 1'b0, 1'b1, 1'b0);
				end
			end else if (cmd == CMD_READ_ASC || cmd == CMD_READ_DESC) begin
				readouts++;
				if (shadow_count == 0) begin
					push_result('0, 1'b0, 1'b1, 1'b0);
				end else begin
					for (int k = 0; k < shadow_count; k++)
						push_result(shadow_values[(cmd == CMD_READ_ASC) ? k : shadow_count-1-k],
							1'b1, k == shadow_count - 1, 1'b0);
				end
			end else begin
				ignored++;
				push_result('0, 1'b0, 1'b1, 1'b0);
			end
		endfunction

		task flag_mismatch(string what);
			mismatches++;
			$display("%0t: mismatch: %s", $time, what);
		endtask

		task check_transfer(logic [M_DATA_W-1:0] data, logic user, logic tlast);
			readout_t e;
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected transfer data=%h user=%b last=%b",
					data, user, tlast));
				return;
			end
			e = pending_results.pop_front();
			checked++;
			if (data[VALUE_W-1:0] !== e.value)
				flag_mismatch($sformatf("value %h, expected %h", data[VALUE_W-1:0], e.value));
			if (user !== e.value_valid)
				flag_mismatch($sformatf("value_valid %b, expected %b", user, e.value_valid));
			if (tlast !== e.last)
				flag_mismatch($sformatf("last %b, expected %b", tlast, e.last));
			if (data[VALUE_W] !== e.list_empty)
				flag_mismatch($sformatf("list_empty %b, expected %b", data[VALUE_W],
					e.list_empty));
			if (data[VALUE_W+1] !== e.status)
				flag_mismatch($sformatf("status %b, expected %b", data[VALUE_W+1], e.status));
			if (data[M_DATA_W-1:VALUE_W+2] !== '0)
				flag_mismatch($sformatf("padding bits not zero: %h", data));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata;
	logic [CMD_W-1:0]    s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic                m_axis_tuser;
	logic                m_axis_tlast;

	sorted_list_tracker tracker = new();
	bit                 long_hold_request;

	sorted_insert_buffer_top #(
		.DEPTH(DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n            = 1'b0;
		s_axis_tvalid     = 1'b0;
		s_axis_tdata      = '0;
		s_axis_tuser      = CMD_INSERT;
		m_axis_tready     = 1'b0;
		long_hold_request = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: checks every transfer and varies tready in stretches of its own.
	initial begin : receiver
		int hold_left;
		int stretch_left;
		int mode;
		hold_left    = 0;
		stretch_left = 0;
		mode         = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_transfer(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			if (stretch_left == 0) begin
				mode         = $urandom_range(0, 2);
				stretch_left = $urandom_range(10, 80);
			end
			stretch_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (long_hold_request) begin
				long_hold_request = 1'b0;
				hold_left         = LONG_HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (!arst_n) begin
				m_axis_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 1) == 0);
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin : sender
		command_item_t      plan[$];
		command_item_t      item;
		logic [VALUE_W-1:0] pool[6];
		logic [VALUE_W-1:0] last_value;
		logic [VALUE_W-1:0] pick_value;
		int                 counted;
		int                 roll;
		int                 total;
		int                 sent;
		int                 burst_left;
		int                 gap;

		// Directed part: empty reads, unused commands, extremes, equal values, both read orders.
		plan.push_back('{cmd: CMD_READ_ASC,  value: 16'hFFFF});
		plan.push_back('{cmd: CMD_READ_DESC, value: 16'h0000});
		plan.push_back('{cmd: CMD_UNUSED,    value: 16'h5A5A});
		plan.push_back('{cmd: CMD_INSERT,    value: 16'hFFFF});
		plan.push_back('{cmd: CMD_INSERT,    value: 16'h0000});
		plan.push_back('{cmd: CMD_INSERT,    value: 16'h8000});
		plan.push_back('{cmd: CMD_INSERT,    value: 16'h8000});
		plan.push_back('{cmd: CMD_INSERT,    value: 16'h7FFF});
		plan.push_back('{cmd: CMD_INSERT,    value: 16'h0100});
		plan.push_back('{cmd: CMD_INSERT,    value: 16'h8001});
		plan.push_back('{cmd: CMD_INSERT,    value: 16'h0000});
		plan.push_back('{cmd: CMD_INSERT,    value: 16'hFFFF});
		plan.push_back('{cmd: CMD_READ_ASC,  value: 16'h1234});
		plan.push_back('{cmd: CMD_READ_DESC, value: 16'hFFFF});
		plan.push_back('{cmd: CMD_UNUSED,    value: 16'hFFFF});
		plan.push_back('{cmd: CMD_READ_ASC,  value: 16'h0000});

		// Random part: the store only grows, so it fills early and later inserts are
		// dropped; a small pool of values makes runs of equal entries likely.
		foreach (pool[i])
			pool[i] = VALUE_W'($urandom);
		last_value = 16'h4000;
		counted    = 0;
		while (counted < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			case ($urandom_range(0, 3))
				0: pick_value = VALUE_W'($urandom);
				1: pick_value = pool[$urandom_range(0, 5)];
				2: pick_value = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
				default: pick_value = last_value + VALUE_W'($urandom_range(0, 4)) - 16'd2;
			endcase
			last_value = pick_value;
			if (roll < 45)
				plan.push_back('{cmd: CMD_INSERT, value: pick_value});
			else if (roll < 70)
				plan.push_back('{cmd: CMD_READ_ASC, value: pick_value});
			else if (roll < 95)
				plan.push_back('{cmd: CMD_READ_DESC, value: pick_value});
			else
				plan.push_back('{cmd: CMD_UNUSED, value: pick_value});
			if (roll < 95)
				counted++;
		end

		total      = plan.size();
		sent       = 0;
		burst_left = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		while (plan.size() > 0) begin
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
					$urandom_range(1, 8);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				if (gap > 0) begin
					s_axis_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			item = plan.pop_front();
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= item.value;
			s_axis_tuser  <= item.cmd;
			do
				@(posedge clk);
			while (!s_axis_tready);
			tracker.note_command(item.cmd, item.value);
			sent++;
			burst_left--;
			// Halfway through, the receiver holds off long enough for the input to stall.
			if (sent == total / 2)
				long_hold_request = 1'b1;
		end
		s_axis_tvalid <= 1'b0;

		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d inserts (%0d dropped on a full store), %0d readouts",
			tracker.inserts, tracker.drops, tracker.readouts);
		$display("and %0d unused commands; %0d result transfers compared, %0d checks failed.",
			tracker.ignored, tracker.checked, tracker.mismatches);
		if (tracker.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
